>>> hw/rtl/assert_macros.svh
// Assertion helpers included by the RTL top module.
// Every check is sampled on the rising clock and is off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every sampled edge.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition that must never be true.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `ASSERT_PROP(label, clk, rst_n, !(cond), msg)

`endif

>>> hw/rtl/pdcm_pkg.sv
// ----------------------------------------------------------------------------
// PWM duty capture meter package
// Shared widths, reset values, register map and result codes.
// ----------------------------------------------------------------------------
`default_nettype none

package pdcm_pkg;

    localparam int STAMP_BITS_DEF = 16;
    localparam int EDGE_TIME_W    = 16;
    localparam int DUTY_W         = 8;
    localparam int TICKS_W        = 8;
    localparam int THR_W          = 16;
    localparam int OFS_W          = 8;
    localparam int CODE_W         = 2;

    // 257 steps per period: x * 257 = (x << 8) + x.
    localparam int DUTY_SHIFT = 8;

    // Register reset values.
    localparam logic [TICKS_W-1:0] TIMEOUT_RST  = 8'd100;
    localparam logic [DUTY_W-1:0]  FALLBACK_RST = 8'd100;
    localparam logic [THR_W-1:0]   FOLD_THR_RST = 16'd10000;
    localparam logic [OFS_W-1:0]   HIGH_OFS_RST = 8'd17;

    // Register indexes (byte address = 4 * index).
    localparam logic [1:0] REG_TIMEOUT  = 2'd0;
    localparam logic [1:0] REG_FALLBACK = 2'd1;
    localparam logic [1:0] REG_FOLD_THR = 2'd2;
    localparam logic [1:0] REG_HIGH_OFS = 2'd3;

    // Result status codes.
    localparam logic [CODE_W-1:0] STAT_BUSY    = 2'd0;
    localparam logic [CODE_W-1:0] STAT_READY   = 2'd1;
    localparam logic [CODE_W-1:0] STAT_TIMEOUT = 2'd2;

    // Awaited edge codes.
    localparam logic [CODE_W-1:0] AWAIT_NONE = 2'd0;
    localparam logic [CODE_W-1:0] AWAIT_RISE = 2'd1;
    localparam logic [CODE_W-1:0] AWAIT_FALL = 2'd2;

    // Capture phases.
    localparam logic [1:0] PH_ARM       = 2'd0;
    localparam logic [1:0] PH_WAIT_RISE = 2'd1;
    localparam logic [1:0] PH_WAIT_FALL = 2'd2;
    localparam logic [1:0] PH_WAIT_NEXT = 2'd3;

    function automatic logic [CODE_W-1:0] wanted_edge(input logic [1:0] phase);
        logic [CODE_W-1:0] code;
        case (phase)
            PH_ARM:       code = AWAIT_NONE;
            PH_WAIT_FALL: code = AWAIT_FALL;
            default:      code = AWAIT_RISE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pwm_duty_capture_meter_top.sv
// ----------------------------------------------------------------------------
// PWM duty capture meter
// Measures high time and period from three capture stamps and reports duty.
// ----------------------------------------------------------------------------
// Each input beat is one poll tick. A tick that does not complete a
// measurement gives its result beat in the cycle after it is taken. The tick
// that brings the closing edge runs a short sequence on one shared adder:
// high time, low time, period, fold check and fold, offset add, multiply by
// 257 as shift plus add, then a restoring division of STAMP_BITS+10 quotient
// bits, one bit per cycle. A closing edge that gives a zero period skips the
// multiply and the division and reports the fallback duty with timeout
// status. The block accepts no new tick while a measurement is in progress
// or while an earlier result beat is still waiting and not being taken.
`default_nettype none

`include "assert_macros.svh"

module pwm_duty_capture_meter_top #(
    parameter int STAMP_BITS = pdcm_pkg::STAMP_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Tick stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [pdcm_pkg::EDGE_TIME_W-1:0] i_s_tdata,   // [15:0] edge_time
    input  wire logic        i_s_tuser,   // [0] edge_seen
    // Result stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,   // [7:0] duty, [9:8] await_edge, rest zero
    output logic [1:0]       o_m_tuser,   // [1:0] status
    // Register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int SB    = STAMP_BITS;
    localparam int QW    = SB + 10;      // dividend and quotient width
    localparam int W     = QW + 1;       // shared adder width, top bit is the sign
    localparam int CNT_W = $clog2(QW);
    localparam int DW    = pdcm_pkg::DUTY_W;
    localparam int CW    = pdcm_pkg::CODE_W;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_HI   = 11'b000_0000_0010,
        S_LO   = 11'b000_0000_0100,
        S_PER  = 11'b000_0000_1000,
        S_CMP  = 11'b000_0001_0000,
        S_ORD  = 11'b000_0010_0000,
        S_FOLD = 11'b000_0100_0000,
        S_OFS  = 11'b000_1000_0000,
        S_MUL  = 11'b001_0000_0000,
        S_DIV  = 11'b010_0000_0000,
        S_DONE = 11'b100_0000_0000
    } t_state;

    // Configuration registers.
    logic [pdcm_pkg::TICKS_W-1:0] r_timeout;
    logic [DW-1:0]                r_fallback;
    logic [pdcm_pkg::THR_W-1:0]   r_fold_thr;
    logic [pdcm_pkg::OFS_W-1:0]   r_high_ofs;

    // Control state.
    t_state                       r_state,      n_state;
    logic [1:0]                   r_phase,      n_phase;
    logic [pdcm_pkg::TICKS_W-1:0] r_ticks,      n_ticks;
    logic [DW-1:0]                r_duty,       n_duty;
    logic                         r_folded,     n_folded;
    logic                         r_hi_gt,      n_hi_gt;
    logic [CNT_W-1:0]             r_cnt,        n_cnt;
    logic                         r_out_valid,  n_out_valid;

    // Datapath.
    logic [SB-1:0] r_rise,  n_rise;
    logic [SB-1:0] r_fall,  n_fall;
    logic [SB-1:0] r_next,  n_next;
    logic [SB-1:0] r_hi,    n_hi;
    logic [SB-1:0] r_lo,    n_lo;
    logic [SB-1:0] r_per,   n_per;
    logic [QW-1:0] r_num,   n_num;
    logic [SB-1:0] r_rem,   n_rem;

    logic [CW-1:0] r_out_status, n_out_status;
    logic [DW-1:0] r_out_duty,   n_out_duty;
    logic [CW-1:0] r_out_await,  n_out_await;

    // Shared adder.
    logic [W-1:0] u_a;
    logic [W-1:0] u_b;
    logic         u_sub;
    logic [W-1:0] u_res;
    logic         u_neg;

    logic          w_in_acc;
    logic          w_out_acc;
    logic          w_cfg_wr;
    logic [31:0]   w_time32;
    logic [SB-1:0] w_stamp;
    logic [SB:0]   w_trial;

    assign u_res = u_a + (u_sub ? ~u_b : u_b) + W'(u_sub);
    assign u_neg = u_res[W-1];

    assign o_s_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_tready);
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_out_acc  = r_out_valid && i_m_tready;
    assign w_time32   = 32'(i_s_tdata);
    assign w_stamp    = w_time32[SB-1:0];
    assign w_trial    = {r_rem, r_num[QW-1]};

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out_await, r_out_duty};
    assign o_m_tuser  = r_out_status;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[3:2])
            pdcm_pkg::REG_TIMEOUT:  prdata = 32'(r_timeout);
            pdcm_pkg::REG_FALLBACK: prdata = 32'(r_fallback);
            pdcm_pkg::REG_FOLD_THR: prdata = 32'(r_fold_thr);
            pdcm_pkg::REG_HIGH_OFS: prdata = 32'(r_high_ofs);
            default:                prdata = 32'd0;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_ticks      = r_ticks;
        n_duty       = r_duty;
        n_folded     = r_folded;
        n_hi_gt      = r_hi_gt;
        n_cnt        = r_cnt;
        n_rise       = r_rise;
        n_fall       = r_fall;
        n_next       = r_next;
        n_hi         = r_hi;
        n_lo         = r_lo;
        n_per        = r_per;
        n_num        = r_num;
        n_rem        = r_rem;
        n_out_valid  = r_out_valid && !w_out_acc;
        n_out_status = r_out_status;
        n_out_duty   = r_out_duty;
        n_out_await  = r_out_await;
        u_a          = '0;
        u_b          = '0;
        u_sub        = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (r_ticks == '0) begin
                        // Timeout: reload, report the fallback, keep the phase.
                        n_ticks      = r_timeout;
                        n_duty       = r_fallback;
                        n_out_valid  = 1'b1;
                        n_out_status = pdcm_pkg::STAT_TIMEOUT;
                        n_out_duty   = r_fallback;
                        n_out_await  = pdcm_pkg::wanted_edge(r_phase);
                    end else begin
                        n_ticks = r_ticks - 1'b1;
                        case (r_phase)
                            pdcm_pkg::PH_ARM: begin
                                n_phase = pdcm_pkg::PH_WAIT_RISE;
                            end
                            pdcm_pkg::PH_WAIT_RISE: begin
                                if (i_s_tuser) begin
                                    n_rise  = w_stamp;
                                    n_phase = pdcm_pkg::PH_WAIT_FALL;
                                end
                            end
                            pdcm_pkg::PH_WAIT_FALL: begin
                                if (i_s_tuser) begin
                                    n_fall  = w_stamp;
                                    n_phase = pdcm_pkg::PH_WAIT_NEXT;
                                end
                            end
                            default: begin
                                if (i_s_tuser) begin
                                    n_next   = w_stamp;
                                    n_ticks  = r_timeout;
                                    n_phase  = pdcm_pkg::PH_ARM;
                                    n_folded = 1'b0;
                                    n_state  = S_HI;
                                end
                            end
                        endcase
                        // The closing edge reports later, from the sequence.
                        if (!(r_phase == pdcm_pkg::PH_WAIT_NEXT && i_s_tuser)) begin
                            n_out_valid  = 1'b1;
                            n_out_status = pdcm_pkg::STAT_BUSY;
                            n_out_duty   = r_duty;
                            n_out_await  = pdcm_pkg::wanted_edge(n_phase);
                        end
                    end
                end
            end
            S_HI: begin
                u_a     = W'(r_fall);
                u_b     = W'(r_rise);
                u_sub   = 1'b1;
                n_hi    = u_res[SB-1:0];
                n_state = S_LO;
            end
            S_LO: begin
                u_a     = W'(r_next);
                u_b     = W'(r_fall);
                u_sub   = 1'b1;
                n_lo    = u_res[SB-1:0];
                n_state = S_PER;
            end
            S_PER: begin
                u_a     = W'(r_hi);
                u_b     = W'(r_lo);
                n_per   = u_res[SB-1:0];
                n_state = r_folded ? S_OFS : S_CMP;
            end
            S_CMP: begin
                // threshold - period goes negative when the period is above it.
                u_a     = W'(r_fold_thr);
                u_b     = W'(r_per);
                u_sub   = 1'b1;
                n_state = u_neg ? S_ORD : S_OFS;
            end
            S_ORD: begin
                u_a     = W'(r_lo);
                u_b     = W'(r_hi);
                u_sub   = 1'b1;
                n_hi_gt = u_neg;
                n_state = S_FOLD;
            end
            S_FOLD: begin
                u_a   = r_hi_gt ? W'(r_hi) : W'(r_lo);
                u_b   = W'(r_per >> 1);
                u_sub = 1'b1;
                if (r_hi_gt) begin
                    n_hi = u_res[SB-1:0];
                end else begin
                    n_lo = u_res[SB-1:0];
                end
                n_folded = 1'b1;
                n_state  = S_PER;
            end
            S_OFS: begin
                if (r_per == '0) begin
                    n_duty       = r_fallback;
                    n_out_valid  = 1'b1;
                    n_out_status = pdcm_pkg::STAT_TIMEOUT;
                    n_out_duty   = r_fallback;
                    n_out_await  = pdcm_pkg::AWAIT_NONE;
                    n_state      = S_IDLE;
                end else begin
                    u_a     = W'(r_hi);
                    u_b     = W'(r_high_ofs);
                    n_num   = u_res[QW-1:0];
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                u_a     = W'(r_num) << pdcm_pkg::DUTY_SHIFT;
                u_b     = W'(r_num);
                n_num   = u_res[QW-1:0];
                n_rem   = '0;
                n_cnt   = CNT_W'(QW - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                // Restoring step: one quotient bit shifts in at the bottom.
                u_a   = W'(w_trial);
                u_b   = W'(r_per);
                u_sub = 1'b1;
                n_rem = u_neg ? w_trial[SB-1:0] : u_res[SB-1:0];
                n_num = {r_num[QW-2:0], ~u_neg};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_duty       = r_num[DW-1:0] - 1'b1;
                n_out_valid  = 1'b1;
                n_out_status = pdcm_pkg::STAT_READY;
                n_out_duty   = r_num[DW-1:0] - 1'b1;
                n_out_await  = pdcm_pkg::AWAIT_NONE;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= pdcm_pkg::TIMEOUT_RST;
            r_fallback  <= pdcm_pkg::FALLBACK_RST;
            r_fold_thr  <= pdcm_pkg::FOLD_THR_RST;
            r_high_ofs  <= pdcm_pkg::HIGH_OFS_RST;
            r_state     <= S_IDLE;
            r_phase     <= pdcm_pkg::PH_ARM;
            r_ticks     <= pdcm_pkg::TIMEOUT_RST;
            r_duty      <= pdcm_pkg::FALLBACK_RST;
            r_folded    <= 1'b0;
            r_hi_gt     <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_rise      <= '0;
            r_fall      <= '0;
        end else begin
            if (w_cfg_wr) begin
                case (paddr[3:2])
                    pdcm_pkg::REG_TIMEOUT:  r_timeout  <= pwdata[pdcm_pkg::TICKS_W-1:0];
                    pdcm_pkg::REG_FALLBACK: r_fallback <= pwdata[DW-1:0];
                    pdcm_pkg::REG_FOLD_THR: r_fold_thr <= pwdata[pdcm_pkg::THR_W-1:0];
                    pdcm_pkg::REG_HIGH_OFS: r_high_ofs <= pwdata[pdcm_pkg::OFS_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_ticks     <= n_ticks;
            r_duty      <= n_duty;
            r_folded    <= n_folded;
            r_hi_gt     <= n_hi_gt;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_rise      <= n_rise;
            r_fall      <= n_fall;
        end
    end

    always_ff @(posedge i_clk) begin
        r_next       <= n_next;
        r_hi         <= n_hi;
        r_lo         <= n_lo;
        r_per        <= n_per;
        r_num        <= n_num;
        r_rem        <= n_rem;
        r_out_status <= n_out_status;
        r_out_duty   <= n_out_duty;
        r_out_await  <= n_out_await;
    end

    // The remainder stays below the divisor through every division step.
    `ASSERT_PROP(a_rem_below_per, i_clk, i_rst_n,
        (r_state == S_DIV) |-> (r_rem < r_per), "division remainder not below period")

    // The last division step always hands over to the result step.
    `ASSERT_PROP(a_div_ends, i_clk, i_rst_n,
        (r_state == S_DIV && r_cnt == '0) |=> (r_state == S_DONE), "division did not end")

    // The result register is free when a measurement completes.
    `ASSERT_NEVER(a_done_slot_busy, i_clk, i_rst_n,
        (r_state == S_DONE) && r_out_valid, "result slot still full at measurement end")

    // A measurement only starts from a tick taken in the last capture phase.
    `ASSERT_PROP(a_start_from_tick, i_clk, i_rst_n,
        (r_state == S_HI) |-> ($past(w_in_acc) && $past(r_phase) == pdcm_pkg::PH_WAIT_NEXT),
        "measurement started without third edge")

endmodule

`default_nettype wire
